// ----- rtl/lzwd_pkg.sv -----
// Shared types, constants and a byte-lane helper for the 12-bit LZW decoder.
package lzwd_pkg;

  localparam int CodeBits     = 12;
  localparam int Literals     = 256;
  localparam int BytesPerWord = 8;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       stream_start;
  } lzwd_in_t;

  typedef struct packed {
    logic [63:0] out_bytes;
    logic [3:0]  byte_count;
    logic        last;
    logic        error;
  } lzwd_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_FB_WAIT,
    ST_APP_RD,
    ST_APP_WR,
    ST_EMIT_RD,
    ST_EMIT_WR,
    ST_ERR_OUT
  } lzwd_state_e;

  // where the string being emitted comes from
  typedef enum logic [1:0] {
    SRC_LIT,
    SRC_DICT,
    SRC_PREV
  } lzwd_src_e;

  typedef struct packed {
    logic      take_in;
    logic      set_err;
    logic      start_first;
    logic      start_later;
    lzwd_src_e src;
    logic      fb_load;
    logic      app_rd;
    logic      app_wr;
    logic      emit_rd;
    logic      emit_wr;
    logic      err_wr;
  } lzwd_cmd_t;

  typedef struct packed {
    logic have_code;
    logic err_flag;
    logic first_seen;
    logic code_lit;
    logic code_in_dict;
    logic prev_bad;
    logic app_last;
    logic emit_last;
    logic out_free;
  } lzwd_status_t;

  // replace one byte lane of a word
  function automatic logic [63:0] put_byte(input logic [63:0] w, input logic [2:0] pos,
                                          input logic [7:0] b);
    logic [63:0] r;
    r = w;
    for (int i = 0; i < BytesPerWord; i++) begin
      if (3'(i) == pos) begin
        r[i*8 +: 8] = b;
      end
    end
    return r;
  endfunction

endpackage

// ----- rtl/lzwd_ram.sv -----
// Generic simple dual-port RAM with registered read.
module lzwd_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/lzwd_ctrl.sv -----
// Controller state machine of the LZW decoder.
module lzwd_ctrl import lzwd_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  lzwd_status_t status_i,
  output lzwd_cmd_t    cmd_o
);

  lzwd_state_e state_q, state_d;
  lzwd_src_e   src_sel;

  // source of a later code
  always_comb begin
    if (status_i.code_lit) begin
      src_sel = SRC_LIT;
    end else if (status_i.code_in_dict) begin
      src_sel = SRC_DICT;
    end else begin
      src_sel = SRC_PREV;
    end
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DECODE;
      end
      ST_DECODE: begin
        if (!status_i.have_code) begin
          state_d = ST_IDLE;
        end else if (status_i.err_flag) begin
          state_d = ST_ERR_OUT;
        end else if (!status_i.first_seen) begin
          state_d = status_i.code_lit ? ST_EMIT_RD : ST_ERR_OUT;
        end else if (status_i.prev_bad) begin
          state_d = ST_ERR_OUT;
        end else begin
          state_d = (src_sel == SRC_DICT) ? ST_FB_WAIT : ST_APP_RD;
        end
      end
      ST_FB_WAIT: state_d = ST_APP_RD;
      ST_APP_RD:  state_d = ST_APP_WR;
      ST_APP_WR:  state_d = status_i.app_last ? ST_EMIT_RD : ST_APP_RD;
      ST_EMIT_RD: state_d = ST_EMIT_WR;
      ST_EMIT_WR: begin
        if (status_i.out_free) state_d = status_i.emit_last ? ST_IDLE : ST_EMIT_RD;
      end
      ST_ERR_OUT: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o      = '0;
    cmd_o.src  = src_sel;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.take_in = in_valid_i;
      end
      ST_DECODE: begin
        if (status_i.have_code && !status_i.err_flag) begin
          if (!status_i.first_seen) begin
            cmd_o.set_err     = !status_i.code_lit;
            cmd_o.start_first = status_i.code_lit;
          end else begin
            cmd_o.set_err     = status_i.prev_bad;
            cmd_o.start_later = !status_i.prev_bad;
          end
        end
      end
      ST_FB_WAIT: cmd_o.fb_load = 1'b1;
      ST_APP_RD:  cmd_o.app_rd  = 1'b1;
      ST_APP_WR:  cmd_o.app_wr  = 1'b1;
      ST_EMIT_RD: cmd_o.emit_rd = 1'b1;
      ST_EMIT_WR: cmd_o.emit_wr = status_i.out_free;
      ST_ERR_OUT: cmd_o.err_wr  = status_i.out_free;
      default: ;
    endcase
  end

endmodule

// ----- rtl/lzwd_datapath.sv -----
// Datapath of the LZW decoder: bit unpacking, dictionary and string buffers.
module lzwd_datapath import lzwd_pkg::*; #(
  parameter int DictEntries = 4096,
  parameter int MaxString   = 256
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  lzwd_in_t     in_data_i,
  input  logic         out_ready_i,
  input  lzwd_cmd_t    cmd_i,
  output lzwd_status_t status_o,
  output logic         out_valid_o,
  output lzwd_out_t    out_data_o
);

  localparam int Words = (MaxString + BytesPerWord - 1) / BytesPerWord;
  localparam int KW    = $clog2(Words);
  localparam int DAW   = $clog2(DictEntries * Words);
  localparam int LAW   = $clog2(DictEntries);

  // control state
  logic [4:0]        held_q;
  logic              have_code_q;
  logic [12:0]       count_q;
  logic [8:0]        prev_len_q;
  logic              first_q, err_q;
  lzwd_src_e         kind_q;
  logic [KW-1:0]     k_q;
  logic              out_valid_q;
  // payload
  logic [15:0]       bitbuf_q;
  logic [CodeBits-1:0] code_q;
  logic [7:0]        fb_q, prev_first_q;
  logic [8:0]        elen_q;
  lzwd_out_t         out_q;

  logic [63:0] dict_rdata, prev_rdata;
  logic [8:0]  len_rdata;

  // unpacking
  logic [15:0] bb_c, nb;
  logic [4:0]  held_c, nh, sh;
  always_comb begin
    bb_c   = in_data_i.stream_start ? 16'd0 : bitbuf_q;
    held_c = in_data_i.stream_start ? 5'd0 : held_q;
    nb     = {bb_c[7:0], in_data_i.in_byte};
    nh     = held_c + 5'd8;
    sh     = nh - 5'(CodeBits);
  end

  // status
  logic [12:0] cnt_eff;
  logic        tail_word, out_free;
  logic [8:0]  emit_len, rem;
  logic [3:0]  cnt;
  always_comb begin
    cnt_eff   = (count_q >= 13'(DictEntries)) ? 13'(Literals) : count_q;
    tail_word = (9'(k_q) == (prev_len_q >> 3));
    out_free  = !out_valid_q || out_ready_i;
    case (kind_q)
      SRC_LIT:  emit_len = 9'd1;
      SRC_DICT: emit_len = (elen_q > 9'(MaxString)) ? 9'(MaxString) : elen_q;
      SRC_PREV: emit_len = prev_len_q + 9'd1;
      default:  emit_len = 9'd1;
    endcase
    rem = emit_len - {k_q, 3'b000};
    cnt = (rem >= 9'd8) ? 4'd8 : rem[3:0];
    status_o.have_code    = have_code_q;
    status_o.err_flag     = err_q;
    status_o.first_seen   = first_q;
    status_o.code_lit     = code_q < CodeBits'(Literals);
    status_o.code_in_dict = 13'(code_q) < cnt_eff;
    status_o.prev_bad     = (prev_len_q >= 9'(MaxString)) || (prev_len_q == 9'd0);
    status_o.app_last     = tail_word;
    status_o.emit_last    = rem <= 9'd8;
    status_o.out_free     = out_free;
  end

  // words written to the dictionary and emitted
  logic [63:0] app_word, emit_word, emit_masked;
  always_comb begin
    app_word = tail_word ? put_byte(prev_rdata, prev_len_q[2:0], fb_q) : prev_rdata;
    case (kind_q)
      SRC_LIT:  emit_word = {56'd0, code_q[7:0]};
      SRC_DICT: emit_word = dict_rdata;
      SRC_PREV: emit_word = app_word;
      default:  emit_word = dict_rdata;
    endcase
    for (int b = 0; b < BytesPerWord; b++) begin
      emit_masked[b*8 +: 8] = (4'(b) < cnt) ? emit_word[b*8 +: 8] : 8'd0;
    end
  end

  // memories
  logic [DAW-1:0] dict_raddr, dict_waddr;
  logic           dict_re, prev_re;
  assign dict_raddr = DAW'(code_q) * DAW'(Words) + DAW'(k_q);
  assign dict_waddr = DAW'(count_q) * DAW'(Words) + DAW'(k_q);
  assign dict_re    = (cmd_i.start_later && cmd_i.src == SRC_DICT) ||
                      (cmd_i.emit_rd && kind_q == SRC_DICT);
  assign prev_re    = cmd_i.app_rd || (cmd_i.emit_rd && kind_q == SRC_PREV);

  lzwd_ram #(.Width(64), .Depth(DictEntries * Words)) u_dict (
    .clk_i  (clk_i),
    .we_i   (cmd_i.app_wr),
    .waddr_i(dict_waddr),
    .wdata_i(app_word),
    .re_i   (dict_re),
    .raddr_i(dict_raddr),
    .rdata_o(dict_rdata)
  );

  lzwd_ram #(.Width(9), .Depth(DictEntries)) u_len (
    .clk_i  (clk_i),
    .we_i   (cmd_i.app_wr && tail_word),
    .waddr_i(LAW'(count_q)),
    .wdata_i(prev_len_q + 9'd1),
    .re_i   (cmd_i.start_later && cmd_i.src == SRC_DICT),
    .raddr_i(LAW'(code_q)),
    .rdata_o(len_rdata)
  );

  lzwd_ram #(.Width(64), .Depth(Words)) u_prev (
    .clk_i  (clk_i),
    .we_i   (cmd_i.emit_wr),
    .waddr_i(k_q),
    .wdata_i(emit_masked),
    .re_i   (prev_re),
    .raddr_i(k_q),
    .rdata_o(prev_rdata)
  );

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q      <= '0;
      have_code_q <= 1'b0;
      count_q     <= 13'(Literals);
      prev_len_q  <= '0;
      first_q     <= 1'b0;
      err_q       <= 1'b0;
      kind_q      <= SRC_LIT;
      k_q         <= '0;
      out_valid_q <= 1'b0;
      bitbuf_q    <= '0;
    end else begin
      if (cmd_i.take_in) begin
        bitbuf_q    <= nb;
        have_code_q <= nh >= 5'(CodeBits);
        held_q      <= (nh >= 5'(CodeBits)) ? sh : nh;
        if (in_data_i.stream_start) begin
          count_q    <= 13'(Literals);
          prev_len_q <= '0;
          first_q    <= 1'b0;
          err_q      <= 1'b0;
        end
      end
      if (cmd_i.set_err) err_q <= 1'b1;
      if (cmd_i.start_first) begin
        first_q <= 1'b1;
        kind_q  <= SRC_LIT;
      end
      if (cmd_i.start_later) begin
        count_q <= cnt_eff;
        kind_q  <= cmd_i.src;
      end
      if (cmd_i.app_wr) begin
        if (tail_word) begin
          k_q     <= '0;
          count_q <= count_q + 13'd1;
        end else begin
          k_q <= k_q + KW'(1);
        end
      end
      if (cmd_i.emit_wr) begin
        if (status_o.emit_last) begin
          k_q        <= '0;
          prev_len_q <= emit_len;
        end else begin
          k_q <= k_q + KW'(1);
        end
      end
      if (cmd_i.emit_wr || cmd_i.err_wr) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_in && nh >= 5'(CodeBits)) begin
      code_q <= CodeBits'(nb >> sh);
    end
    if (cmd_i.start_first) fb_q <= code_q[7:0];
    if (cmd_i.start_later) begin
      fb_q <= (cmd_i.src == SRC_PREV) ? prev_first_q : code_q[7:0];
    end
    if (cmd_i.fb_load) begin
      fb_q   <= dict_rdata[7:0];
      elen_q <= len_rdata;
    end
    if (cmd_i.emit_wr && status_o.emit_last) prev_first_q <= fb_q;
    if (cmd_i.emit_wr) begin
      out_q <= '{out_bytes: emit_masked, byte_count: cnt, last: status_o.emit_last,
                 error: 1'b0};
    end else if (cmd_i.err_wr) begin
      out_q <= '{out_bytes: 64'd0, byte_count: 4'd0, last: 1'b1, error: 1'b1};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- rtl/lzw_decoder_12bit.sv -----
// LZW decoder top level: 12-bit codes in packed bytes, up to eight decoded bytes per word out.
// A byte completing no code passes the idle and decode states. A code is decoded, a dictionary
// code waits for its lookup, a new entry is appended word by word in a read and a write state
// and output words are emitted alike, stalling while the output is full. The rate is set by the
// registered single read port of the dictionary and previous-string RAMs. One item at a time.
// Reset is asynchronous and clears control state; dictionary RAM contents are not cleared.
module lzw_decoder_12bit import lzwd_pkg::*; #(
  parameter int DICT_ENTRIES = 4096,
  parameter int MAX_STRING   = 256
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  lzwd_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output lzwd_out_t out_data_o
);

  lzwd_cmd_t    cmd;
  lzwd_status_t status;

  // sequencer
  lzwd_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  // storage and arithmetic
  lzwd_datapath #(.DictEntries(DICT_ENTRIES), .MaxString(MAX_STRING)) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .out_ready_i(out_ready_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_valid_o(out_valid_o),
    .out_data_o (out_data_o)
  );

  // error word carries no bytes and closes the code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.error |-> out_data_o.byte_count == 4'd0 && out_data_o.last)
    else $error("error word malformed");

  // a data word has one to eight bytes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.error |->
      out_data_o.byte_count != 4'd0 && out_data_o.byte_count <= 4'd8)
    else $error("bad byte count");

  // only the final word of a code may be short
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.error && out_data_o.byte_count != 4'd8 |-> out_data_o.last)
    else $error("short word before end of code");

endmodule

// ----- bench/lzw_decoder_12bit_tb.sv -----
// Testbench for the 12-bit LZW decoder: directed table plus random code streams.
`timescale 1ns / 1ps

module lzw_decoder_12bit_tb;
  import lzwd_pkg::*;

  localparam int DictEntries = 4096;
  localparam int MaxString   = 256;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  lzwd_in_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  lzwd_out_t out_data_o;

  lzw_decoder_12bit #(.DICT_ENTRIES(DictEntries), .MAX_STRING(MaxString)) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  // Predictor state
  logic [7:0]  dict_bytes [DictEntries][MaxString];
  int unsigned dict_len [DictEntries];
  logic [7:0]  prev_str [MaxString];
  int unsigned prev_len;
  logic [15:0] bitbuf;
  int unsigned nbits;
  int unsigned dict_count;
  bit          seen_first;
  bit          sticky_err;

  lzwd_out_t   decoded_words[$];
  int unsigned mismatches = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          hold_off = 1'b0;

  // Predict the decoded words for one accepted byte
  task automatic decode_byte(input lzwd_in_t it);
    logic [7:0]  str [MaxString];
    int unsigned slen;
    int unsigned code;
    lzwd_out_t   w;
    if (it.stream_start) begin
      bitbuf = '0; nbits = 0; dict_count = Literals; prev_len = 0;
      seen_first = 0; sticky_err = 0;
    end
    bitbuf = {bitbuf[7:0], it.in_byte};
    nbits += 8;
    if (nbits < CodeBits) return;
    nbits -= CodeBits;
    code = (bitbuf >> nbits) & 16'hFFF;
    w = '0; w.last = 1'b1; w.error = 1'b1;
    if (sticky_err) begin
      decoded_words.push_back(w);
      return;
    end
    if (!seen_first) begin
      if (code >= Literals) begin
        sticky_err = 1; decoded_words.push_back(w); return;
      end
      seen_first = 1; str[0] = code[7:0]; slen = 1;
    end else begin
      if (prev_len >= MaxString || prev_len == 0) begin
        sticky_err = 1; decoded_words.push_back(w); return;
      end
      if (dict_count >= DictEntries) dict_count = Literals;
      if (code < Literals) begin
        str[0] = code[7:0]; slen = 1;
      end else if (code < dict_count) begin
        slen = dict_len[code];
        if (slen > MaxString) slen = MaxString;
        for (int i = 0; i < slen; i++) str[i] = dict_bytes[code][i];
      end else begin
        for (int i = 0; i < prev_len; i++) str[i] = prev_str[i];
        str[prev_len] = prev_str[0];
        slen = prev_len + 1;
      end
      if (dict_count < DictEntries) begin
        for (int i = 0; i < prev_len; i++) dict_bytes[dict_count][i] = prev_str[i];
        dict_bytes[dict_count][prev_len] = str[0];
        dict_len[dict_count] = prev_len + 1;
        dict_count++;
      end
    end
    for (int i = 0; i < slen; i++) prev_str[i] = str[i];
    prev_len = slen;
    for (int k = 0; k < slen; k += 8) begin
      w = '0;
      for (int b = 0; b < 8 && k + b < slen; b++) begin
        w.out_bytes[b*8 +: 8] = str[k+b];
        w.byte_count++;
      end
      w.last = (k + 8 >= slen);
      decoded_words.push_back(w);
    end
  endtask

  // Input accept and output check at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) decode_byte(in_data_i);
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (decoded_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", out_data_o);
      end else begin
        lzwd_out_t e;
        e = decoded_words.pop_front();
        if (e !== out_data_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"word mismatch: exp bytes=%h cnt=%0d last=%b err=%b, ",
                      "got bytes=%h cnt=%0d last=%b err=%b"},
                     e.out_bytes, e.byte_count, e.last, e.error, out_data_o.out_bytes,
                     out_data_o.byte_count, out_data_o.last, out_data_o.error);
        end
      end
    end
  end

  // Receiver: random stalls, with an optional long hold-off
  always @(negedge clk_i) begin
    if (hold_off) out_ready_i <= 1'b0;
    else out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Send one byte on a later falling edge, idling at random beforehand
  task automatic send_byte(input logic [7:0] b, input bit start);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= '{in_byte: b, stream_start: start};
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  // Pack a code list into bytes, MSB first, and send them
  task automatic send_codes(input int unsigned codes[$]);
    logic [7:0] bytes[$];
    logic [3:0] pend;
    bit         half;
    half = 0;
    foreach (codes[i]) begin
      if (!half) begin
        bytes.push_back(codes[i][11:4]);
        pend = codes[i][3:0];
        half = 1;
      end else begin
        bytes.push_back({pend, codes[i][11:8]});
        bytes.push_back(codes[i][7:0]);
        half = 0;
      end
    end
    if (half) bytes.push_back({pend, 4'h0});
    foreach (bytes[i]) send_byte(bytes[i], i == 0);
  endtask

  task automatic wait_drained();
    while (decoded_words.size() != 0) @(negedge clk_i);
    repeat (150) @(negedge clk_i);
  endtask

  // Random well-formed stream of n codes, a few odd codes mixed in
  task automatic random_stream(input int unsigned n);
    int unsigned codes[$];
    int unsigned cnt;
    cnt = Literals;
    codes.push_back($urandom_range(255));
    for (int i = 1; i < n; i++) begin
      case ($urandom_range(9))
        0, 1, 2: codes.push_back($urandom_range(255));
        3:       codes.push_back(cnt);
        9:       codes.push_back($urandom_range(4095));
        default: codes.push_back($urandom_range(cnt - 1));
      endcase
      if (cnt < DictEntries) cnt++;
    end
    send_codes(codes);
  endtask

  typedef struct {
    logic [7:0] in_byte;
    bit         start;
    bit         check_err;
  } stim_row_t;

  // Directed table: literals at extremes, growing code, self-reference, bad first code
  stim_row_t stim_table[] = '{
    '{8'h00, 1, 0}, '{8'h00, 0, 0}, '{8'hFF, 0, 0},           // 0x000, 0x0FF
    '{8'h10, 0, 0}, '{8'h01, 0, 0}, '{8'h01, 0, 0},           // 0x100, 0x101
    '{8'hAA, 1, 0}, '{8'h50, 0, 0}, '{8'h55, 0, 0},           // 0xAA5, 0x055
    '{8'hFF, 1, 0}, '{8'hF0, 0, 1},                           // first code 0xFFF
    '{8'h12, 0, 1}, '{8'h34, 0, 0}, '{8'h56, 0, 1},           // still sticky
    '{8'h7F, 1, 0}, '{8'hF8, 0, 0}, '{8'h00, 0, 0},           // 0x7FF first: error
    '{8'h01, 1, 0}, '{8'h31, 0, 0}, '{8'h00, 0, 0}            // 0x013, 0x100
  };

  initial begin
    int unsigned phase_items;
    bit          before_err;
    lzwd_out_t   err_word;
    lzwd_out_t   got_word;
    err_word = '0; err_word.last = 1'b1; err_word.error = 1'b1;
    bitbuf = '0; nbits = 0; dict_count = Literals; prev_len = 0;
    seen_first = 0; sticky_err = 0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part; error rows cross-check the predictor against a typed word
    foreach (stim_table[i]) begin
      before_err = stim_table[i].check_err;
      send_byte(stim_table[i].in_byte, stim_table[i].start);
      if (before_err && (decoded_words.size() == 0 || decoded_words[$] != err_word)) begin
        mismatches++;
        got_word = (decoded_words.size() == 0) ? '0 : decoded_words[$];
        if (mismatches <= 10)
          $display("row %0d: exp %h, got %h", i, err_word, got_word);
      end
    end
    wait_drained();

    // Long receiver hold-off so the block fills and stalls input
    fork
      begin
        hold_off = 1'b1;
        repeat (400) @(negedge clk_i);
        hold_off = 1'b0;
      end
      random_stream(12);
    join
    wait_drained();

    // Random phases: receiver slow, sender slow, then free running
    for (int p = 0; p < 3; p++) begin
      send_idle_pct = (p == 0) ? 27 : (p == 1) ? 66 : 0;
      recv_idle_pct = (p == 0) ? 66 : (p == 1) ? 27 : 0;
      phase_items = 0;
      while (phase_items < 12) begin
        int unsigned n;
        n = $urandom_range(4, 10);
        random_stream(n);
        phase_items += (n * 3 + 1) / 2;
        if ($urandom_range(3) == 0) wait_drained();
      end
    end
    // Long strings: repeated self-reference run
    begin
      int unsigned codes[$];
      int unsigned cnt;
      codes.push_back(8'h5A);
      cnt = Literals;
      for (int i = 0; i < 20; i++) begin
        codes.push_back(cnt);
        cnt++;
      end
      send_codes(codes);
    end
    wait_drained();

    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ----- lzw_decoder_12bit.f -----
rtl/lzwd_pkg.sv
rtl/lzwd_ram.sv
rtl/lzwd_ctrl.sv
rtl/lzwd_datapath.sv
rtl/lzw_decoder_12bit.sv
bench/lzw_decoder_12bit_tb.sv
